// ===== rtl/core/ptt_pkg.sv =====
// shared types and constants for the packet timeout table
package ptt_pkg;

   localparam int unsigned KEY_W  = 32;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned LIMIT_W = 26;

   // timeout_ticks / 100 as multiply by reciprocal then shift right by 37
   localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
   localparam int unsigned DIV100_SHIFT = 37;

   localparam logic [31:0]        TIMEOUT_RESET = 32'd1000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 26'd10;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_QUERY = 2'd3
   } act_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } stat_type;

   // request token walking along the row of cells
   typedef struct packed {
      logic              valid;
      act_type           action;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] now;
      logic              done;
      logic              expired;
   } tok_type;

endpackage

// ===== rtl/core/ptt_if.sv =====
// request and response channel interfaces of the packet timeout table
interface ptt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] packet_key;
   logic [31:0] now_time;

   modport source (output valid, output action, output packet_key, output now_time,
                   input ready);
   modport sink (input valid, input action, input packet_key, input now_time,
                 output ready);
endinterface

interface ptt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       expired;

   modport source (output valid, output status, output expired, input ready);
   modport sink (input valid, input status, input expired, output ready);
endinterface

// ===== rtl/core/ptt_limit.sv =====
// timeout register, held as its scaled expiry limit
module ptt_limit
   import ptt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [31:0]        wr_data,
   output logic [LIMIT_W-1:0] limit
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic [63:0]        prod;

   // scale on the way in so the new limit is live at the write edge
   assign prod     = {32'd0, wr_data} * {32'd0, DIV100_MAGIC};
   assign limit_in = wr_en ? prod[DIV100_SHIFT+LIMIT_W-1:DIV100_SHIFT] : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign limit = limit_ff;

endmodule

// ===== rtl/core/ptt_cell.sv =====
// one timer entry, acting on the request token as it passes
module ptt_cell
   import ptt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [LIMIT_W-1:0] limit,
   input  tok_type            tok_i,
   output tok_type            tok_o
);

   logic              valid_ff, valid_in;
   logic              run_ff, run_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [TIME_W-1:0] sent_ff, sent_in;
   tok_type           tok_ff, tok_in;
   logic              hit;
   logic [TIME_W-1:0] elapsed;
   logic              late;

   assign elapsed = tok_i.now - sent_ff;
   assign late    = elapsed > {{(TIME_W-LIMIT_W){1'b0}}, limit};

   always_comb begin
      hit = 1'b0;
      if (tok_i.valid && !tok_i.done) begin
         if (tok_i.action == ACT_ADD) begin
            hit = !valid_ff;
         end else begin
            hit = valid_ff && (key_ff == tok_i.key);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      run_in   = run_ff;
      key_in   = key_ff;
      sent_in  = sent_ff;
      tok_in   = tok_i;
      if (hit) begin
         tok_in.done = 1'b1;
         case (tok_i.action)
            ACT_ADD: begin
               valid_in = 1'b1;
               key_in   = tok_i.key;
               sent_in  = tok_i.now;
               run_in   = 1'b0;
            end
            ACT_START: begin
               sent_in = tok_i.now;
               run_in  = 1'b1;
            end
            ACT_STOP: begin
               run_in = 1'b0;
            end
            ACT_QUERY: begin
               tok_in.expired = run_ff && late;
            end
            default: begin
               run_in = run_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         run_ff       <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
         run_ff   <= run_in;
         key_ff   <= key_in;
         sent_ff  <= sent_in;
         tok_ff   <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

// ===== rtl/core/packet_timeout_table_core.sv =====
// packet timeout table: retransmission timers in a row of entry cells
//
// req_chan takes a request of action, packet key and current time under
// valid/ready; rsp_chan returns one response of status and expired per
// request, also under valid/ready. csr_wr_en/csr_wr_data write the timeout
// register (expiry limit is timeout / 100); the user must write it only while
// no request is in flight, the block does not enforce this. a request walks
// the row of TABLE_DEPTH cells, one cell per cycle unless the row is held; the
// first cell that matches (first free cell for an add) acts on it and marks it
// done. the token passes through the cell registers, then the response
// register. one request is in flight at a time, until it leaves the row.
// a new request is taken while the previous response still waits in the
// output register. if the receiver stalls and a second response is ready,
// the whole row holds until the output register frees up.
// reset clears every entry's valid and running marks, the request in flight
// and the response valid; timeout returns to 1000.
module packet_timeout_table_core
   import ptt_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   ptt_req_if.sink     req_chan,
   ptt_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   tok_type            tok [0:TABLE_DEPTH];
   tok_type            last;
   logic [LIMIT_W-1:0] limit;
   logic               advance;
   logic               req_take;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   stat_type           rsp_status_ff, rsp_status_in;
   logic               rsp_expired_ff, rsp_expired_in;
   logic               finish;

   // timeout register and derived limit
   ptt_limit u_limit (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .wr_data (csr_wr_data),
      .limit   (limit)
   );

   // one request in flight at a time
   assign req_chan.ready = !busy_ff;
   assign req_take       = req_chan.valid && !busy_ff;

   always_comb begin
      tok[0].valid   = req_take;
      tok[0].action  = act_type'(req_chan.action);
      tok[0].key     = req_chan.packet_key;
      tok[0].now     = req_chan.now_time;
      tok[0].done    = 1'b0;
      tok[0].expired = 1'b0;
   end

   // row of entry cells, the token moves one cell a cycle while the row is not held
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ptt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .limit   (limit),
         .tok_i   (tok[i]),
         .tok_o   (tok[i+1])
      );
   end

   assign last = tok[TABLE_DEPTH];

   // hold the row while a finished token cannot leave
   assign advance = !(last.valid && rsp_valid_ff && !rsp_chan.ready);
   assign finish  = last.valid && advance;

   always_comb begin
      busy_in = busy_ff;
      if (req_take) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_expired_in = rsp_expired_ff;
      if (finish) begin
         rsp_valid_in   = 1'b1;
         rsp_expired_in = last.expired;
         if (last.done) begin
            rsp_status_in = ST_OK;
         end else if (last.action == ACT_ADD) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_expired_ff <= rsp_expired_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.expired = rsp_expired_ff;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the packet timeout table core
`timescale 1ns / 1ps

module testbench;
   import ptt_pkg::*;

   // table size and the divisor that turns the timeout register into a tick limit
   localparam int          DEPTH        = 16;
   localparam logic [31:0] TIMEOUT_DIV  = 32'd100;
   // one request in flight, walking DEPTH cells plus the output register
   localparam int          LATENCY      = DEPTH + 1;
   localparam int          TAIL_CYCLES  = 4 * LATENCY;
   localparam int          PHASE_REQS   = 205;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          HOLD_AFTER   = 400;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int          PRINT_LIMIT  = 40;
   localparam logic [31:0] KEY_STRIDE   = 32'h2468_ACE1;

   // one expected response, tagged with the request number for messages
   typedef struct packed {
      int unsigned seq;
      stat_type    status;
      logic        expired;
   } resp_type;

   // one row of the directed table; reps > 1 repeats an add with stepped keys
   typedef struct packed {
      act_type     action;
      logic [31:0] key;
      logic [31:0] now;
      int          reps;
      bit          typed;
      stat_type    status;
      logic        expired;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   ptt_req_if req_chan ();
   ptt_rsp_if rsp_chan ();

   packet_timeout_table_core #(.TABLE_DEPTH(DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the timer table and the timeout register
   logic        ent_valid [DEPTH];
   logic [31:0] ent_key   [DEPTH];
   logic [31:0] ent_sent  [DEPTH];
   logic        ent_run   [DEPTH];
   int          ent_count;
   logic [31:0] tmo_ticks;

   // responses still owed by the block, oldest first
   resp_type resp_due_q [$];

   int unsigned requests_sent = 0;
   int unsigned responses_seen = 0;
   int unsigned mismatches = 0;
   int unsigned ok_seen = 0;
   int unsigned missing_seen = 0;
   int unsigned full_seen = 0;
   int unsigned expiries_seen = 0;
   int unsigned timeouts_written = 0;
   bit          no_gaps = 1'b0;
   bit          rsp_hold = 1'b0;

   // directed requests: empty table, extremes, duplicate key, wrap, boundary, full
   stim_row_type dir_rows [15] = '{
      // lookups on an empty table all miss
      '{ACT_QUERY, 32'h0000_0000, 32'h0000_0000,  1, 1'b1, ST_NOT_FOUND, 1'b0},
      '{ACT_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  1, 1'b1, ST_NOT_FOUND, 1'b0},
      '{ACT_STOP,  32'h1234_5678, 32'h0000_0000,  1, 1'b1, ST_NOT_FOUND, 1'b0},
      // extreme keys and send times, then a duplicate of key zero
      '{ACT_ADD,   32'h0000_0000, 32'h0000_0000,  1, 1'b1, ST_OK,        1'b0},
      '{ACT_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF,  1, 1'b1, ST_OK,        1'b0},
      '{ACT_ADD,   32'h0000_0000, 32'h0000_0005,  1, 1'b1, ST_OK,        1'b0},
      // arm near the top of the time range so the next query wraps
      '{ACT_START, 32'hFFFF_FFFF, 32'hFFFF_FFF0,  1, 1'b0, ST_OK,        1'b0},
      '{ACT_QUERY, 32'hFFFF_FFFF, 32'h0000_0004,  1, 1'b0, ST_OK,        1'b0},
      // elapsed exactly at the limit, then one tick past it
      '{ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFA,  1, 1'b0, ST_OK,        1'b0},
      '{ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFB,  1, 1'b0, ST_OK,        1'b0},
      // duplicate key: start must land on the earlier entry
      '{ACT_START, 32'h0000_0000, 32'h8000_0000,  1, 1'b0, ST_OK,        1'b0},
      '{ACT_STOP,  32'hFFFF_FFFF, 32'h0000_0000,  1, 1'b0, ST_OK,        1'b0},
      '{ACT_QUERY, 32'hFFFF_FFFF, 32'h7FFF_FFFF,  1, 1'b0, ST_OK,        1'b0},
      // fill the remaining slots, then one add too many
      '{ACT_ADD,   32'h1357_9BDF, 32'h0000_0100, 13, 1'b1, ST_OK,        1'b0},
      '{ACT_ADD,   32'hDEAD_0001, 32'h0000_0000,  1, 1'b1, ST_FULL,      1'b0}
   };

   // timeout settings for the random phases, extremes first; last one is drawn
   logic [31:0] tmo_plan [6] = '{32'd0, 32'hFFFF_FFFF, 32'd99, 32'd100, 32'd1000, 32'd0};

   function automatic logic [31:0] expiry_limit();
      return tmo_ticks / TIMEOUT_DIV;
   endfunction

   // first valid entry holding the key, or -1
   function automatic int timer_lookup(input logic [31:0] key);
      for (int i = 0; i < DEPTH; i++)
         if (ent_valid[i] && ent_key[i] == key)
            return i;
      return -1;
   endfunction

   function automatic void timer_table_clear();
      for (int i = 0; i < DEPTH; i++) begin
         ent_valid[i] = 1'b0;
         ent_key[i]   = '0;
         ent_sent[i]  = '0;
         ent_run[i]   = 1'b0;
      end
      ent_count = 0;
      tmo_ticks = 32'd1000;
   endfunction

   // apply one request to the shadow table and work out its response
   function automatic void timer_table_step(input act_type act, input logic [31:0] key,
                                            input logic [31:0] now, output stat_type st,
                                            output logic expired);
      int          idx;
      logic [31:0] elapsed;
      st      = ST_OK;
      expired = 1'b0;
      if (act == ACT_ADD) begin
         if (ent_count >= DEPTH)
            st = ST_FULL;
         else begin
            ent_valid[ent_count] = 1'b1;
            ent_key[ent_count]   = key;
            ent_sent[ent_count]  = now;
            ent_run[ent_count]   = 1'b0;
            ent_count++;
         end
      end else begin
         idx = timer_lookup(key);
         if (idx < 0)
            st = ST_NOT_FOUND;
         else begin
            case (act)
               ACT_START: begin
                  ent_sent[idx] = now;
                  ent_run[idx]  = 1'b1;
               end
               ACT_STOP:
                  ent_run[idx] = 1'b0;
               default: begin
                  // modular difference handles the time wrap
                  elapsed = now - ent_sent[idx];
                  expired = ent_run[idx] && (elapsed > expiry_limit());
               end
            endcase
         end
      end
   endfunction

   task automatic flag_mismatch(input string what);
      if (mismatches < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   // offer one request, wait for the handshake, then record what is owed
   task automatic send_request(input act_type act, input logic [31:0] key,
                               input logic [31:0] now, input bit typed,
                               input resp_type typed_resp);
      int       gap;
      stat_type st;
      logic     expired;
      resp_type due;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.packet_key <= key;
      req_chan.now_time   <= now;
      do @(posedge clock); while (!req_chan.ready);
      timer_table_step(act, key, now, st, expired);
      if (typed)
         due = typed_resp;
      else begin
         due.status  = st;
         due.expired = expired;
      end
      due.seq = requests_sent;
      resp_due_q.push_back(due);
      requests_sent++;
   endtask

   // random request: mostly keys already in the table, half the hits timed near the expiry edge
   task automatic random_request();
      act_type     act;
      logic [31:0] key;
      logic [31:0] now;
      int          pick;
      int          idx;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         act = ACT_ADD;
      else if (pick < 35)
         act = ACT_START;
      else if (pick < 50)
         act = ACT_STOP;
      else
         act = ACT_QUERY;
      pick = $urandom_range(0, 99);
      if (pick < 85 && ent_count > 0)
         key = ent_key[$urandom_range(0, ent_count - 1)];
      else if (pick < 92 && ent_count > 0)
         key = ent_key[$urandom_range(0, ent_count - 1)] ^ (32'h1 << $urandom_range(0, 31));
      else
         key = $urandom;
      now = $urandom;
      idx = timer_lookup(key);
      // half the hits land within two ticks either side of the limit
      if (idx >= 0 && $urandom_range(0, 1) == 1)
         now = ent_sent[idx] + expiry_limit() + $urandom_range(0, 4) - 32'd2;
      send_request(act, key, now, 1'b0, '0);
   endtask

   // register write, only ever called with nothing in flight
   task automatic write_timeout(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tmo_ticks = value;
      timeouts_written++;
   endtask

   // compare one accepted response with the oldest expectation
   task automatic check_response();
      resp_type due;
      responses_seen++;
      case (rsp_chan.status)
         ST_OK:        ok_seen++;
         ST_NOT_FOUND: missing_seen++;
         ST_FULL:      full_seen++;
         default:      ;
      endcase
      if (rsp_chan.expired === 1'b1)
         expiries_seen++;
      if (resp_due_q.size() == 0) begin
         flag_mismatch($sformatf("response with nothing outstanding (status %0d)",
                                 rsp_chan.status));
         return;
      end
      due = resp_due_q.pop_front();
      if (rsp_chan.status !== due.status)
         flag_mismatch($sformatf("request %0d status %0d, expected %0d",
                                 due.seq, rsp_chan.status, due.status));
      if (rsp_chan.expired !== due.expired)
         flag_mismatch($sformatf("request %0d expired %b, expected %b",
                                 due.seq, rsp_chan.expired, due.expired));
   endtask

   // response side: random stalls after each response, plus the long hold-off
   initial begin : rsp_side
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            check_response();
            stall = no_gaps ? 0 : $urandom_range(0, 5);
         end
         if (rsp_hold || stall != 0) begin
            rsp_chan.ready <= 1'b0;
            if (!rsp_hold)
               stall--;
         end else
            rsp_chan.ready <= 1'b1;
      end
   end

   // long receiver hold-off mid-run; the sender keeps offering so the core backs up
   initial begin : rsp_pressure
      wait (requests_sent >= HOLD_AFTER);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("run stopped after %0d cycles with %0d responses owed",
               cycles, resp_due_q.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      resp_type typed_resp;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ACT_ADD;
      req_chan.packet_key <= '0;
      req_chan.now_time   <= '0;
      rsp_chan.ready      <= 1'b0;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      timer_table_clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset timeout (limit of ten ticks)
      foreach (dir_rows[r]) begin
         for (int n = 0; n < dir_rows[r].reps; n++) begin
            typed_resp = '{seq: 0, status: dir_rows[r].status,
                           expired: dir_rows[r].expired};
            send_request(dir_rows[r].action, dir_rows[r].key + n * KEY_STRIDE,
                         dir_rows[r].now + n * 7, dir_rows[r].typed, typed_resp);
         end
      end

      // random phases, one timeout setting each, written with the core drained
      tmo_plan[5] = $urandom_range(200, 100000);
      foreach (tmo_plan[ph]) begin
         req_chan.valid <= 1'b0;
         while (resp_due_q.size() != 0) @(posedge clock);
         write_timeout(tmo_plan[ph]);
         // every third phase runs back to back on both sides
         no_gaps <= (ph % 3 == 1);
         repeat (PHASE_REQS) random_request();
      end

      req_chan.valid <= 1'b0;
      while (resp_due_q.size() != 0) @(posedge clock);
      // catch any stray response after the last one owed
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests over %0d timeout settings, %0d responses checked",
               requests_sent, timeouts_written, responses_seen);
      $display("outcomes: %0d ok, %0d key missing, %0d table full, %0d expiries, %0d mismatches",
               ok_seen, missing_seen, full_seen, expiries_seen, mismatches);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
